FILE: rtl/core/ppt_pkg.sv
// Shared types, constants and helper functions of the polyline progress tracker.
// No dependencies; imported by polyline_progress_tracker.
package ppt_pkg;

    localparam int VAL_W      = 32;   // coordinate word, Q16.16
    localparam int TOL_W      = 31;   // tolerance register
    localparam int SEGLEN_W   = 32;   // stored segment length, Q18.14
    localparam int LEN_W      = 48;   // covered and total length
    localparam int ACC_W      = 64;   // wide working accumulators
    localparam int SEGIDX_W   = 6;    // reported segment index
    localparam int IN_TDATA_W = 96;   // three packed coordinates
    localparam int MUL_W      = 33;   // signed multiplier operand

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STAT_TRACKED   = 1'b0;
    localparam logic STAT_EXHAUSTED = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L_MUL,
        ST_L_DRN,
        ST_L_SQRT,
        ST_L_WR,
        ST_Q_PRE,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_DOT,
        ST_Q_DOTW,
        ST_Q_DIV,
        ST_Q_SQ,
        ST_Q_SQW,
        ST_Q_TEST,
        ST_Q_PDIV,
        ST_Q_FIN,
        ST_EMIT
    } ppt_state_t;

    // Destination of the product that leaves the shared multiplier.
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_DD,
        ACC_WD,
        ACC_WW,
        ACC_TSQ,
        ACC_BT_LO,
        ACC_BT_HI,
        ACC_SQ_LO,
        ACC_SQ_MID
    } ppt_acc_t;

    // Coordinate difference divided by four, truncated toward zero.
    function automatic logic signed [30:0] diff_div4(input logic [VAL_W-1:0] a,
                                                     input logic [VAL_W-1:0] b);
        logic signed [VAL_W:0] d;
        logic signed [VAL_W:0] adj;
        d   = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
        adj = d + (d[VAL_W] ? 33'sd3 : 33'sd0);
        return adj[VAL_W:2];
    endfunction

endpackage

FILE: rtl/core/polyline_progress_tracker.sv
// Top level of the polyline progress tracker: vertex and segment-length memories,
// a load/query sequencer, a shared multiplier, a square-root unit and a divider.
// Depends on ppt_pkg.

// Polyline progress tracker. Load words (s_tuser = 0) append one vertex of a
// polyline to the vertex memory and, from the second vertex on, compute the
// new segment length with a bit-pair square root and add it to the total
// length; a load with s_tlast set closes the polyline and clears the progress
// state, and the next load starts a fresh polyline. Query words (s_tuser = 1)
// walk the segments from the current one, projecting the point onto each in
// turn, and return one result word: progress as a Q1.FRAC_BITS fraction with
// segment index (status 0), or progress 1.0 when the walk runs past the last
// segment or the polyline has no length (status 1, sticky until the next
// closing load). Loads return no word. The block takes one word at a time;
// any vertex after the first takes one multiply per axis, then 32 square-root
// steps. A query walks its segments one after another, each dominated by the
// 64-step restoring divider, which also forms the final progress fraction in
// a second pass when the accepted point lies beyond the polyline start. Each
// segment needs two reads of the single-read-port vertex memory, so those
// reads are serialized. Exhausted or degenerate queries go straight to the
// result stage. The result sits in an output register, so a new word is
// taken while the previous result still waits. dist_tolerance is written
// through cfg_wr_en/cfg_wr_data while idle; the user is bound to this, as
// the block itself does not enforce it.
module polyline_progress_tracker #(
    parameter int DIM          = 3,
    parameter int MAX_VERTICES = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration: dist_tolerance, Q16.16
    input  logic                                   cfg_wr_en,
    input  logic [ppt_pkg::TOL_W-1:0]              cfg_wr_data,
    // input words
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: coord_0 [31:0], coord_1 [63:32], coord_2 [95:64]
    input  logic [ppt_pkg::IN_TDATA_W-1:0]         s_tdata,
    // tuser: cmd
    input  logic                                   s_tuser,
    // tlast: last_vertex
    input  logic                                   s_tlast,
    // result words
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: progress [FRAC_BITS:0], segment_index [FRAC_BITS+6:FRAC_BITS+1], zero pad
    output logic [((FRAC_BITS + 14) / 8) * 8-1:0]  m_tdata,
    // tuser: status
    output logic                                   m_tuser
);
    import ppt_pkg::*;

    localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int SW    = (CW > SEGIDX_W) ? CW : SEGIDX_W;
    localparam int PW    = FRAC_BITS + 1;
    localparam int OUT_W = ((FRAC_BITS + 14) / 8) * 8;
    localparam int VW    = DIM * VAL_W;
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

    // Control state
    ppt_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg;
    logic               closed_reg;
    logic [SW-1:0]      cur_seg_reg;
    logic [LEN_W-1:0]   covered_reg;
    logic [LEN_W-1:0]   total_reg;
    logic [PW-1:0]      best_reg;
    logic               exh_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic               m_tvalid_reg;

    // Datapath
    logic [VW-1:0]      pt_reg, prev_reg, a_reg;
    logic [SW-1:0]      seg_reg;
    logic [SEGLEN_W-1:0] len_reg;
    logic [IW-1:0]      wr_idx_reg;
    logic [1:0]         t_reg, k_reg;
    logic [ACC_W-1:0]   dd_reg, wd_reg, ww_reg, tsq_reg, bt_reg, a2_reg, num_reg;
    logic [ACC_W-1:0]   dd_next, wd_next, ww_next;
    logic [ACC_W-1:0]   sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [ACC_W-1:0]   div_n_reg, div_q_reg;
    logic [LEN_W-1:0]   div_d_reg, div_rem_reg;
    logic [5:0]         div_cnt_reg;
    logic [PW-1:0]      res_prog_reg, m_prog_reg;
    logic               res_stat_reg, m_stat_reg;
    logic [SEGIDX_W-1:0] res_seg_reg, m_seg_reg;

    // Shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_full;
    ppt_acc_t                  mul_tag, mul_tag_reg;
    logic [ACC_W-1:0]          mul_p_reg;

    // Memories
    logic [VW-1:0]       vmem [MAX_VERTICES];
    logic [SEGLEN_W-1:0] lmem [MAX_VERTICES];
    logic                v_we, v_re;
    logic [IW-1:0]       v_wr_addr, v_rd_addr;
    logic [VW-1:0]       v_rd_data_reg;
    logic                l_we;
    logic [SEGLEN_W-1:0] l_rd_data_reg;

    // Divider control
    logic               div_start;
    logic [ACC_W-1:0]   div_n_init;
    logic [LEN_W-1:0]   div_d_init;
    logic               div_done;
    logic [LEN_W:0]     div_sh;

    // Misc combinational
    logic               s_fire, is_load, store_ok, degenerate;
    logic [CW-1:0]      cnt_use, nseg;
    logic [SW-1:0]      nseg_w, seg_inc;
    logic [ACC_W-1:0]   wd_abs, mag, along, num_calc, perp2, lag, sq_try;
    logic               far, past, reject, num_pos;
    logic [VAL_W-1:0]   ax, bx, px, qx, lx;
    logic [PW-1:0]      p_fin;

    assign s_fire     = s_tvalid && s_tready;
    assign is_load    = (s_tuser == CMD_LOAD);
    assign cnt_use    = closed_reg ? '0 : count_reg;
    assign store_ok   = (cnt_use < CW'(MAX_VERTICES));
    assign nseg       = (count_reg > CW'(1)) ? count_reg - CW'(1) : '0;
    assign nseg_w     = SW'(nseg);
    assign seg_inc    = seg_reg + SW'(1);
    assign degenerate = exh_reg || (total_reg == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = OUT_W'({m_seg_reg, m_prog_reg});

    // Accumulators with the product that is landing this cycle.
    assign dd_next = (mul_tag_reg == ACC_DD) ? dd_reg + mul_p_reg : dd_reg;
    assign wd_next = (mul_tag_reg == ACC_WD) ? wd_reg + mul_p_reg : wd_reg;
    assign ww_next = (mul_tag_reg == ACC_WW) ? ww_reg + mul_p_reg : ww_reg;
    assign wd_abs  = wd_next[ACC_W-1] ? -wd_next : wd_next;

    // Along-distance from the divider; zero for a zero-length segment.
    assign mag      = (len_reg == '0) ? '0 : div_q_reg;
    assign along    = wd_reg[ACC_W-1] ? -mag : mag;
    assign num_calc = along + ACC_W'(covered_reg);

    // Segment acceptance tests, all in wrapping 64-bit arithmetic.
    assign perp2   = (ww_reg > a2_reg) ? ww_reg - a2_reg : '0;
    assign far     = perp2 > (tsq_reg >> 4);
    assign past    = $signed(wd_reg) > $signed(dd_reg);
    assign lag     = (num_reg << (FRAC_BITS + 1)) - (bt_reg << 1)
                     + (ACC_W'(tol_reg) << FRAC_BITS);
    assign reject  = far || past || lag[ACC_W-1];
    assign num_pos = !num_reg[ACC_W-1] && (num_reg != '0);

    // Final progress fraction, clamped to one.
    assign p_fin = (div_q_reg < ACC_W'(ONE)) ? div_q_reg[PW-1:0] : ONE;

    assign sq_try = sq_r_reg + sq_bit_reg;

    assign div_done = (div_cnt_reg == 6'd63);
    assign div_sh   = {div_rem_reg, div_n_reg[ACC_W-1]};

    assign mul_full = mul_a * mul_b;

    // Per-axis operands for the multiply sequences.
    always_comb begin
        ax = a_reg[k_reg * VAL_W +: VAL_W];
        bx = v_rd_data_reg[k_reg * VAL_W +: VAL_W];
        px = pt_reg[k_reg * VAL_W +: VAL_W];
        qx = prev_reg[t_reg * VAL_W +: VAL_W];
        lx = pt_reg[t_reg * VAL_W +: VAL_W];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (is_load) begin
                        if (store_ok && (cnt_use != '0)) begin
                            state_next = ST_L_MUL;
                        end
                    end else if (degenerate || (cur_seg_reg >= nseg_w)) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_Q_PRE;
                    end
                end
            end
            ST_L_MUL:  if (t_reg == 2'(DIM - 1)) state_next = ST_L_DRN;
            ST_L_DRN:  state_next = ST_L_SQRT;
            ST_L_SQRT: if (sq_bit_reg[0]) state_next = ST_L_WR;
            ST_L_WR:   state_next = ST_IDLE;
            ST_Q_PRE:  if (t_reg == 2'd2) state_next = ST_Q_RDA;
            ST_Q_RDA:  state_next = ST_Q_RDB;
            ST_Q_RDB:  state_next = ST_Q_DOT;
            ST_Q_DOT: begin
                if ((k_reg == 2'(DIM - 1)) && (t_reg == 2'd2)) state_next = ST_Q_DOTW;
            end
            ST_Q_DOTW: state_next = ST_Q_DIV;
            ST_Q_DIV:  if (div_done) state_next = ST_Q_SQ;
            ST_Q_SQ:   if (t_reg == 2'd1) state_next = ST_Q_SQW;
            ST_Q_SQW:  state_next = ST_Q_TEST;
            ST_Q_TEST: begin
                if (reject) begin
                    state_next = (seg_inc < nseg_w) ? ST_Q_RDA : ST_EMIT;
                end else begin
                    state_next = num_pos ? ST_Q_PDIV : ST_EMIT;
                end
            end
            ST_Q_PDIV: if (div_done) state_next = ST_Q_FIN;
            ST_Q_FIN:  state_next = ST_EMIT;
            ST_EMIT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory, multiplier and divider controls.
    always_comb begin
        v_we       = 1'b0;
        v_wr_addr  = cnt_use[IW-1:0];
        v_re       = 1'b0;
        v_rd_addr  = seg_reg[IW-1:0];
        l_we       = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_tag    = ACC_NONE;
        div_start  = 1'b0;
        div_n_init = wd_abs;
        div_d_init = LEN_W'(len_reg);
        unique case (state_reg)
            ST_IDLE: begin
                v_we = s_fire && is_load && store_ok;
            end
            ST_L_MUL: begin
                mul_a   = MUL_W'(diff_div4(lx, qx));
                mul_b   = MUL_W'(diff_div4(lx, qx));
                mul_tag = ACC_DD;
            end
            ST_L_WR: begin
                l_we = 1'b1;
            end
            ST_Q_PRE: begin
                case (t_reg)
                    2'd0: begin
                        mul_a   = $signed(MUL_W'(tol_reg));
                        mul_b   = $signed(MUL_W'(tol_reg));
                        mul_tag = ACC_TSQ;
                    end
                    2'd1: begin
                        mul_a   = $signed(MUL_W'(best_reg));
                        mul_b   = $signed(MUL_W'(total_reg[31:0]));
                        mul_tag = ACC_BT_LO;
                    end
                    default: begin
                        mul_a   = $signed(MUL_W'(best_reg));
                        mul_b   = $signed(MUL_W'(total_reg[LEN_W-1:32]));
                        mul_tag = ACC_BT_HI;
                    end
                endcase
            end
            ST_Q_RDA: begin
                v_re = 1'b1;
            end
            ST_Q_RDB: begin
                v_re      = 1'b1;
                v_rd_addr = seg_inc[IW-1:0];
            end
            ST_Q_DOT: begin
                case (t_reg)
                    2'd0: begin
                        mul_a   = MUL_W'(diff_div4(bx, ax));
                        mul_b   = MUL_W'(diff_div4(bx, ax));
                        mul_tag = ACC_DD;
                    end
                    2'd1: begin
                        mul_a   = MUL_W'(diff_div4(bx, ax));
                        mul_b   = MUL_W'(diff_div4(px, ax));
                        mul_tag = ACC_WD;
                    end
                    default: begin
                        mul_a   = MUL_W'(diff_div4(px, ax));
                        mul_b   = MUL_W'(diff_div4(px, ax));
                        mul_tag = ACC_WW;
                    end
                endcase
            end
            ST_Q_DOTW: begin
                div_start = 1'b1;
            end
            ST_Q_SQ: begin
                // mag^2 mod 2^64 from a low-half square and one cross product.
                mul_b = $signed(MUL_W'(mag[31:0]));
                if (t_reg == 2'd0) begin
                    mul_a   = $signed(MUL_W'(mag[31:0]));
                    mul_tag = ACC_SQ_LO;
                end else begin
                    mul_a   = $signed(MUL_W'(mag[ACC_W-1:32]));
                    mul_tag = ACC_SQ_MID;
                end
            end
            ST_Q_TEST: begin
                div_start  = !reject && num_pos;
                div_n_init = num_reg << FRAC_BITS;
                div_d_init = total_reg;
            end
            default: begin
            end
        endcase
    end

    // Memories: one write and one registered read port each.
    always_ff @(posedge aclk) begin
        if (v_we) begin
            vmem[v_wr_addr] <= s_tdata[VW-1:0];
        end
        if (v_re) begin
            v_rd_data_reg <= vmem[v_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (l_we) begin
            lmem[wr_idx_reg] <= sq_r_reg[SEGLEN_W-1:0];
        end
        if (v_re && (state_reg == ST_Q_RDA)) begin
            l_rd_data_reg <= lmem[v_rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            closed_reg   <= 1'b0;
            cur_seg_reg  <= '0;
            covered_reg  <= '0;
            total_reg    <= '0;
            best_reg     <= '0;
            exh_reg      <= 1'b0;
            tol_reg      <= TOL_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            // A new result enters the output register when it is empty or
            // being drained; otherwise a taken word empties it.
            if ((state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && is_load) begin
                        // A load after a closed polyline starts a new one.
                        closed_reg <= s_tlast;
                        if (closed_reg) begin
                            total_reg <= '0;
                        end
                        count_reg <= store_ok ? cnt_use + CW'(1) : cnt_use;
                        if (s_tlast) begin
                            cur_seg_reg <= '0;
                            covered_reg <= '0;
                            best_reg    <= '0;
                            exh_reg     <= 1'b0;
                        end
                    end else if (s_fire && !degenerate && (cur_seg_reg >= nseg_w)) begin
                        exh_reg <= 1'b1;
                    end
                end
                ST_L_WR: begin
                    total_reg <= total_reg + LEN_W'(sq_r_reg[SEGLEN_W-1:0]);
                end
                ST_Q_TEST: begin
                    if (reject) begin
                        covered_reg <= covered_reg + LEN_W'(len_reg);
                        if (seg_inc >= nseg_w) begin
                            exh_reg     <= 1'b1;
                            cur_seg_reg <= seg_inc;
                        end
                    end else if (!num_pos) begin
                        cur_seg_reg <= seg_reg;
                    end
                end
                ST_Q_FIN: begin
                    cur_seg_reg <= seg_reg;
                    if (p_fin > best_reg) begin
                        best_reg <= p_fin;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mul_p_reg   <= mul_full[ACC_W-1:0];
        mul_tag_reg <= mul_tag;

        // The sums restart at the start of each segment; dd also restarts when a word is taken.
        dd_reg <= (s_fire || (state_reg == ST_Q_RDA)) ? '0 : dd_next;
        wd_reg <= (state_reg == ST_Q_RDA) ? '0 : wd_next;
        ww_reg <= (state_reg == ST_Q_RDA) ? '0 : ww_next;
        case (mul_tag_reg)
            ACC_TSQ:    tsq_reg <= mul_p_reg;
            ACC_BT_LO:  bt_reg  <= mul_p_reg;
            ACC_BT_HI:  bt_reg  <= bt_reg + (mul_p_reg << 32);
            ACC_SQ_LO:  a2_reg  <= mul_p_reg;
            ACC_SQ_MID: a2_reg  <= a2_reg + (mul_p_reg << 33);
            default: begin
            end
        endcase

        // Step counters restart whenever the state changes.
        if (state_next != state_reg) begin
            t_reg <= '0;
            k_reg <= '0;
        end else if ((state_reg == ST_Q_DOT) && (t_reg == 2'd2)) begin
            t_reg <= '0;
            k_reg <= k_reg + 2'd1;
        end else begin
            t_reg <= t_reg + 2'd1;
        end

        // Divider: restoring, one quotient bit a cycle.
        if (div_start) begin
            div_n_reg   <= div_n_init;
            div_d_reg   <= div_d_init;
            div_rem_reg <= '0;
            div_q_reg   <= '0;
            div_cnt_reg <= '0;
        end else if ((state_reg == ST_Q_DIV) || (state_reg == ST_Q_PDIV)) begin
            div_n_reg   <= div_n_reg << 1;
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (div_sh >= {1'b0, div_d_reg}) begin
                div_rem_reg <= LEN_W'(div_sh - {1'b0, div_d_reg});
                div_q_reg   <= {div_q_reg[ACC_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= div_sh[LEN_W-1:0];
                div_q_reg   <= {div_q_reg[ACC_W-2:0], 1'b0};
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    pt_reg     <= s_tdata[VW-1:0];
                    seg_reg    <= cur_seg_reg;
                    wr_idx_reg <= IW'(cnt_use - CW'(1));
                    if (is_load && store_ok && (cnt_use == '0)) begin
                        prev_reg <= s_tdata[VW-1:0];
                    end
                    res_prog_reg <= ONE;
                    res_stat_reg <= STAT_EXHAUSTED;
                    res_seg_reg  <= '0;
                end
            end
            ST_L_DRN: begin
                sq_n_reg   <= dd_next;
                sq_r_reg   <= '0;
                sq_bit_reg <= ACC_W'(1) << 62;
            end
            ST_L_SQRT: begin
                if (sq_n_reg >= sq_try) begin
                    sq_n_reg <= sq_n_reg - sq_try;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_L_WR: begin
                prev_reg <= pt_reg;
            end
            ST_Q_RDB: begin
                a_reg   <= v_rd_data_reg;
                len_reg <= l_rd_data_reg;
            end
            ST_Q_SQ: begin
                num_reg <= num_calc;
            end
            ST_Q_TEST: begin
                if (reject) begin
                    seg_reg      <= seg_inc;
                    res_prog_reg <= ONE;
                    res_stat_reg <= STAT_EXHAUSTED;
                    res_seg_reg  <= '0;
                end else begin
                    res_prog_reg <= '0;
                    res_stat_reg <= STAT_TRACKED;
                    res_seg_reg  <= seg_reg[SEGIDX_W-1:0];
                end
            end
            ST_Q_PDIV: begin
                if (div_done) begin
                    res_prog_reg <= ONE;
                end
            end
            ST_Q_FIN: begin
                res_prog_reg <= p_fin;
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_prog_reg <= res_prog_reg;
                    m_stat_reg <= res_stat_reg;
                    m_seg_reg  <= res_seg_reg;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // An exhausted result always reports full progress at index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_EXHAUSTED)) |->
            ((m_tdata[PW-1:0] == ONE) && (m_tdata[PW +: SEGIDX_W] == '0)))
        else $error("exhausted result with wrong payload");

    // Best progress is a clamped fraction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        best_reg <= ONE)
        else $error("best progress above one");

    // A query always leaves idle to produce its result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_tuser == CMD_QUERY)) |=> (state_reg != ST_IDLE))
        else $error("query taken without a result");

    // Segment lengths written to memory fit the stored width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_L_WR) |-> (sq_r_reg[ACC_W-1:SEGLEN_W] == '0))
        else $error("segment length overflow");
`endif

endmodule
